/* rtl/qrs_pkg.sv */
package qrs_pkg;

  // Field widths of the request and result
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned ROOT_W  = 40;

  // Arithmetic sizing
  localparam int unsigned COEF_WIDTH = 16;
  localparam int unsigned FRAC_BITS  = 16;

  // Discriminant magnitude: b*b + 4*|a*c| stays below 2^(2*COEF_WIDTH+1)
  localparam int unsigned PROD_W = 2 * COEF_WIDTH;
  localparam int unsigned DISC_W = 2 * COEF_WIDTH + 1;
  // Square root: one root bit per sqrt cell
  localparam int unsigned SQRT_W = (DISC_W + 2 * FRAC_BITS + 1) / 2;
  localparam int unsigned RAD_W  = 2 * SQRT_W;
  localparam int unsigned REM_W  = SQRT_W + 2;
  // Numerator magnitude and signed sum widths
  localparam int unsigned BASE_W = COEF_WIDTH - 1 + FRAC_BITS;
  localparam int unsigned MAG_W  = ((BASE_W > SQRT_W) ? BASE_W : SQRT_W) + 1;
  localparam int unsigned SUM_W  = MAG_W + 1;
  // Divisor 2*|a|
  localparam int unsigned DEN_W  = COEF_WIDTH + 1;
  localparam int unsigned DREM_W = DEN_W + 1;
  // Width used for saturation
  localparam int unsigned SAT_W  = (SUM_W > ROOT_W) ? SUM_W : ROOT_W;

  typedef enum logic [1:0] {
    ST_TWO    = 2'd0,
    ST_DOUBLE = 2'd1,
    ST_NONE   = 2'd2,
    ST_AZERO  = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] coef_a;
    logic signed [FIELD_W-1:0] coef_b;
    logic signed [FIELD_W-1:0] coef_c;
  } in_t;

  typedef struct packed {
    logic signed [ROOT_W-1:0] root_plus;
    logic signed [ROOT_W-1:0] root_minus;
    status_t                  root_status;
  } out_t;

  // Sqrt lane carried from cell to cell
  typedef struct packed {
    logic                         valid;
    status_t                      status;
    logic signed [COEF_WIDTH-1:0] a;
    logic signed [COEF_WIDTH-1:0] b;
    logic [RAD_W-1:0]             rad;
    logic [REM_W-1:0]             rem;
    logic [SQRT_W-1:0]            root;
  } sq_t;

  // Divider lane, both roots side by side
  typedef struct packed {
    logic              valid;
    status_t           status;
    logic [DEN_W-1:0]  den;
    logic [MAG_W-1:0]  nump;
    logic [MAG_W-1:0]  numm;
    logic [DREM_W-1:0] remp;
    logic [DREM_W-1:0] remm;
    logic [MAG_W-1:0]  qp;
    logic [MAG_W-1:0]  qm;
    logic              negp;
    logic              negm;
  } dv_t;

  // Clamp a signed value into the root range
  function automatic logic [ROOT_W-1:0] sat_root(input logic signed [SAT_W-1:0] v);
    logic [SAT_W-ROOT_W:0] top;
    logic [ROOT_W-1:0]     res;
    top = v[SAT_W-1:ROOT_W-1];
    if ((top == '0) || (top == '1)) begin
      res = v[ROOT_W-1:0];
    end else if (v[SAT_W-1]) begin
      res = {1'b1, {(ROOT_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(ROOT_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

/* rtl/quadratic_root_solver_core.sv */
// Quadratic root solver: one request carries coefficients a, b, c; one result
// carries both real roots in signed fixed point and a status code.
// Channels: in_valid/in_stall/in_data on the request side, out_valid/out_stall/
// out_data on the result side; a transfer happens when valid is high and
// stall is low at a rising edge.
// Throughput: one request per cycle, sustained while out_stall is low.
// Pipeline: two discriminant stages, one sqrt cell per root bit, a numerator
// stage, one divider cell per quotient bit, and the output register.
// The whole pipeline moves as one: while the output register holds a result
// that the receiver stalls, every stage holds and in_stall is raised, so no
// result is lost or repeated. Results leave in request order.
// Reset (rst_n low, synchronous) clears all stage valid flags; data in
// flight is dropped and the output goes invalid.
module quadratic_root_solver_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  qrs_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output qrs_pkg::out_t out_data
);

  localparam int unsigned SW   = qrs_pkg::SQRT_W;
  localparam int unsigned MW   = qrs_pkg::MAG_W;
  localparam int unsigned SUMW = qrs_pkg::SUM_W;
  localparam int unsigned CW   = qrs_pkg::COEF_WIDTH;

  logic adv;
  logic out_valid_r;
  qrs_pkg::out_t out_data_r, out_nxt;

  qrs_pkg::sq_t sq_chain [0:SW];
  qrs_pkg::dv_t dv_chain [0:MW];
  qrs_pkg::dv_t prep_nxt, prep_r;

  // Global advance: stall only when the held result is not taken
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  qrs_disc u_disc (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (in_valid),
    .in_data  (in_data),
    .cell_o   (sq_chain[0])
  );

  // Square root chain
  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .cell_i (sq_chain[i]),
      .cell_o (sq_chain[i+1])
    );
  end

  // Numerators -b*2^F +/- s and divisor 2|a|
  logic signed [SUMW-1:0] base, sx, nump, numm;
  logic [CW-1:0]          amag;
  logic                   aneg;

  always_comb begin
    aneg = sq_chain[SW].a[CW-1];
    amag = aneg ? CW'(-sq_chain[SW].a) : CW'(sq_chain[SW].a);
    base = -(SUMW'(sq_chain[SW].b) <<< qrs_pkg::FRAC_BITS);
    sx   = signed'(SUMW'(sq_chain[SW].root));
    nump = base + sx;
    numm = base - sx;
    prep_nxt        = '0;
    prep_nxt.valid  = sq_chain[SW].valid;
    prep_nxt.status = sq_chain[SW].status;
    prep_nxt.den    = {amag, 1'b0};
    prep_nxt.nump   = nump[SUMW-1] ? MW'(-nump) : MW'(nump);
    prep_nxt.numm   = numm[SUMW-1] ? MW'(-numm) : MW'(numm);
    prep_nxt.negp   = nump[SUMW-1] ^ aneg;
    prep_nxt.negm   = numm[SUMW-1] ^ aneg;
  end

  // Only the valid flag is reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_r.valid <= 1'b0;
    end else if (adv) begin
      prep_r.valid <= prep_nxt.valid;
    end
    if (adv) begin
      prep_r.status <= prep_nxt.status;
      prep_r.den    <= prep_nxt.den;
      prep_r.nump   <= prep_nxt.nump;
      prep_r.numm   <= prep_nxt.numm;
      prep_r.remp   <= prep_nxt.remp;
      prep_r.remm   <= prep_nxt.remm;
      prep_r.qp     <= prep_nxt.qp;
      prep_r.qm     <= prep_nxt.qm;
      prep_r.negp   <= prep_nxt.negp;
      prep_r.negm   <= prep_nxt.negm;
    end
  end

  assign dv_chain[0] = prep_r;

  // Divider chain
  for (genvar j = 0; j < MW; j++) begin : g_div
    qrs_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .cell_i (dv_chain[j]),
      .cell_o (dv_chain[j+1])
    );
  end

  // Sign, saturate, zero roots for the special cases
  logic signed [SUMW-1:0] qps, qms;

  always_comb begin
    qps = dv_chain[MW].negp ? -SUMW'(dv_chain[MW].qp) : SUMW'(dv_chain[MW].qp);
    qms = dv_chain[MW].negm ? -SUMW'(dv_chain[MW].qm) : SUMW'(dv_chain[MW].qm);
    out_nxt.root_status = dv_chain[MW].status;
    if ((dv_chain[MW].status == qrs_pkg::ST_NONE) ||
        (dv_chain[MW].status == qrs_pkg::ST_AZERO)) begin
      out_nxt.root_plus  = '0;
      out_nxt.root_minus = '0;
    end else begin
      out_nxt.root_plus  = qrs_pkg::sat_root(qrs_pkg::SAT_W'(qps));
      out_nxt.root_minus = qrs_pkg::sat_root(qrs_pkg::SAT_W'(qms));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_chain[MW].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("request taken while result is held");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("held result changed");

  a_zero_roots: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_data.root_status == qrs_pkg::ST_NONE) ||
                   (out_data.root_status == qrs_pkg::ST_AZERO)))
    |-> ((out_data.root_plus == '0) && (out_data.root_minus == '0)))
    else $error("special case with nonzero roots");

  a_double: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.root_status == qrs_pkg::ST_DOUBLE))
    |-> (out_data.root_plus == out_data.root_minus))
    else $error("double root with different roots");

  a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
    sq_chain[SW].valid |->
      (sq_chain[SW].rem <= qrs_pkg::REM_W'({sq_chain[SW].root, 1'b0})))
    else $error("sqrt remainder out of bound");

endmodule

/* rtl/qrs_disc.sv */
module qrs_disc (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_valid,
  input  qrs_pkg::in_t in_data,
  output qrs_pkg::sq_t cell_o
);

  localparam int unsigned CW = qrs_pkg::COEF_WIDTH;

  logic signed [CW-1:0] a, b, c;
  logic [CW-1:0]        amag, bmag, cmag;

  // Stage 1 registers
  logic                        v1_r;
  logic signed [CW-1:0]        a1_r, b1_r;
  logic                        opp1_r;
  logic [qrs_pkg::PROD_W-1:0]  bb1_r, ac1_r;
  logic                        opp_nxt;

  // Stage 2 combine
  logic [qrs_pkg::DISC_W-1:0]  bbx, fac, d;
  qrs_pkg::status_t            st;
  qrs_pkg::sq_t                cell_nxt, cell_r;

  assign a = signed'(in_data.coef_a[CW-1:0]);
  assign b = signed'(in_data.coef_b[CW-1:0]);
  assign c = signed'(in_data.coef_c[CW-1:0]);
  assign amag = a[CW-1] ? CW'(-a) : CW'(a);
  assign bmag = b[CW-1] ? CW'(-b) : CW'(b);
  assign cmag = c[CW-1] ? CW'(-c) : CW'(c);
  // a and c of opposite sign make -4ac positive
  assign opp_nxt = (a[CW-1] != c[CW-1]) && (c != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r   <= a;
      b1_r   <= b;
      opp1_r <= opp_nxt;
      bb1_r  <= bmag * bmag;
      ac1_r  <= amag * cmag;
    end
  end

  // Discriminant and status
  assign bbx = qrs_pkg::DISC_W'(bb1_r);
  assign fac = {ac1_r[qrs_pkg::PROD_W-2:0], 2'b00};

  always_comb begin
    priority if (a1_r == '0) begin
      st = qrs_pkg::ST_AZERO;
      d  = '0;
    end else if (opp1_r) begin
      st = qrs_pkg::ST_TWO;
      d  = bbx + fac;
    end else if (bbx > fac) begin
      st = qrs_pkg::ST_TWO;
      d  = bbx - fac;
    end else if (bbx == fac) begin
      st = qrs_pkg::ST_DOUBLE;
      d  = '0;
    end else begin
      st = qrs_pkg::ST_NONE;
      d  = '0;
    end
  end

  always_comb begin
    cell_nxt        = '0;
    cell_nxt.valid  = v1_r;
    cell_nxt.status = st;
    cell_nxt.a      = a1_r;
    cell_nxt.b      = b1_r;
    cell_nxt.rad    = qrs_pkg::RAD_W'(d) << (2 * qrs_pkg::FRAC_BITS);
  end

  // Only the valid flag is reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r.valid <= cell_nxt.valid;
    end
    if (en) begin
      cell_r.status <= cell_nxt.status;
      cell_r.a      <= cell_nxt.a;
      cell_r.b      <= cell_nxt.b;
      cell_r.rad    <= cell_nxt.rad;
      cell_r.rem    <= cell_nxt.rem;
      cell_r.root   <= cell_nxt.root;
    end
  end

  assign cell_o = cell_r;

endmodule

/* rtl/qrs_sqrt_cell.sv */
module qrs_sqrt_cell (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  qrs_pkg::sq_t cell_i,
  output qrs_pkg::sq_t cell_o
);

  localparam int unsigned SW = qrs_pkg::SQRT_W;
  localparam int unsigned RW = qrs_pkg::RAD_W;

  logic [qrs_pkg::REM_W-1:0] rem_sh, trial;
  logic                      ge;
  qrs_pkg::sq_t              cell_nxt, cell_r;

  // One root bit: bring down two radicand bits, try 4*root+1
  assign rem_sh = {cell_i.rem[SW-1:0], cell_i.rad[RW-1:RW-2]};
  assign trial  = {cell_i.root, 2'b01};
  assign ge     = rem_sh >= trial;

  always_comb begin
    cell_nxt      = cell_i;
    cell_nxt.rad  = cell_i.rad << 2;
    cell_nxt.rem  = ge ? (rem_sh - trial) : rem_sh;
    cell_nxt.root = {cell_i.root[SW-2:0], ge};
  end

  // Only the valid flag is reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r.valid <= cell_nxt.valid;
    end
    if (en) begin
      cell_r.status <= cell_nxt.status;
      cell_r.a      <= cell_nxt.a;
      cell_r.b      <= cell_nxt.b;
      cell_r.rad    <= cell_nxt.rad;
      cell_r.rem    <= cell_nxt.rem;
      cell_r.root   <= cell_nxt.root;
    end
  end

  assign cell_o = cell_r;

endmodule

/* rtl/qrs_div_cell.sv */
module qrs_div_cell (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  qrs_pkg::dv_t cell_i,
  output qrs_pkg::dv_t cell_o
);

  localparam int unsigned MW = qrs_pkg::MAG_W;
  localparam int unsigned DW = qrs_pkg::DEN_W;

  logic [qrs_pkg::DREM_W-1:0] den_x, shp, shm;
  logic                       gep, gem;
  qrs_pkg::dv_t               cell_nxt, cell_r;

  // Restoring step on both numerators against the shared divisor
  assign den_x = {1'b0, cell_i.den};
  assign shp   = {cell_i.remp[DW-1:0], cell_i.nump[MW-1]};
  assign shm   = {cell_i.remm[DW-1:0], cell_i.numm[MW-1]};
  assign gep   = shp >= den_x;
  assign gem   = shm >= den_x;

  always_comb begin
    cell_nxt      = cell_i;
    cell_nxt.nump = cell_i.nump << 1;
    cell_nxt.numm = cell_i.numm << 1;
    cell_nxt.remp = gep ? (shp - den_x) : shp;
    cell_nxt.remm = gem ? (shm - den_x) : shm;
    cell_nxt.qp   = {cell_i.qp[MW-2:0], gep};
    cell_nxt.qm   = {cell_i.qm[MW-2:0], gem};
  end

  // Only the valid flag is reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r.valid <= cell_nxt.valid;
    end
    if (en) begin
      cell_r.status <= cell_nxt.status;
      cell_r.den    <= cell_nxt.den;
      cell_r.nump   <= cell_nxt.nump;
      cell_r.numm   <= cell_nxt.numm;
      cell_r.remp   <= cell_nxt.remp;
      cell_r.remm   <= cell_nxt.remm;
      cell_r.qp     <= cell_nxt.qp;
      cell_r.qm     <= cell_nxt.qm;
      cell_r.negp   <= cell_nxt.negp;
      cell_r.negm   <= cell_nxt.negm;
    end
  end

  assign cell_o = cell_r;

endmodule
